FILE: rtl/core/mpc_pkg.sv
// Shared types and constants for the midpoint circle generator.
// No dependencies; every other file of the block uses this package.
package mpc_pkg;

   localparam int COORD_BITS  = 10;
   localparam int PIX_BITS    = COORD_BITS + 2;
   localparam int SX_BITS     = COORD_BITS + 1;
   localparam int MODE_BITS   = 8;
   localparam int CNT_BITS    = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [CNT_BITS-1:0] LAST_START_PIX = CNT_BITS'(3);
   localparam logic [CNT_BITS-1:0] LAST_STEP_PIX  = CNT_BITS'(7);

   typedef struct packed {
      logic                  is_step;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [MODE_BITS-1:0]  mode;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  fin;
   } job_type;

endpackage

FILE: rtl/core/mpc_if.sv
// Valid/ready channel interfaces for request items and pixel beats.
// Depends on mpc_pkg.
interface mpc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [mpc_pkg::COORD_BITS-1:0] center_x;
   logic [mpc_pkg::COORD_BITS-1:0] center_y;
   logic [mpc_pkg::COORD_BITS-1:0] radius_in;
   logic [mpc_pkg::MODE_BITS-1:0]  draw_mode;

   modport source (output valid, op, center_x, center_y, radius_in, draw_mode, input ready);
   modport sink   (input valid, op, center_x, center_y, radius_in, draw_mode, output ready);
endinterface

interface mpc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mpc_pkg::PIX_BITS-1:0] pixel_x;
   logic signed [mpc_pkg::PIX_BITS-1:0] pixel_y;
   logic [mpc_pkg::MODE_BITS-1:0]       pixel_mode;
   logic                                last;
   logic                                done_res;

   modport source (output valid, pixel_x, pixel_y, pixel_mode, last, done_res, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_mode, last, done_res, output ready);
endinterface

FILE: rtl/core/mpc_front.sv
// Front end: accepts request beats, runs the octant error update and
// pushes one pixel job per productive item. Depends on mpc_pkg, mpc_if.
module mpc_front (
   input  logic               clock,
   input  logic               reset,
   mpc_req_if.sink            req,
   input  logic               queue_full,
   output logic               push,
   output mpc_pkg::job_type   push_job
);

   logic [mpc_pkg::COORD_BITS-1:0] cx_ff, cx_in;
   logic [mpc_pkg::COORD_BITS-1:0] cy_ff, cy_in;
   logic [mpc_pkg::MODE_BITS-1:0]  mode_ff, mode_in;
   logic [mpc_pkg::COORD_BITS-1:0] off_x_ff, off_x_in;
   logic [mpc_pkg::COORD_BITS-1:0] off_y_ff, off_y_in;
   logic [mpc_pkg::PIX_BITS-1:0]   err_ff, err_in;
   logic [mpc_pkg::SX_BITS-1:0]    step_x_ff, step_x_in;
   logic [mpc_pkg::PIX_BITS-1:0]   step_y_ff, step_y_in;
   logic                           active_ff, active_in;

   logic                           accept;
   logic                           is_start;
   logic                           err_nonneg;
   logic [mpc_pkg::COORD_BITS-1:0] off_y_mid;
   logic [mpc_pkg::PIX_BITS-1:0]   step_y_mid;
   logic [mpc_pkg::PIX_BITS-1:0]   err_mid;
   logic [mpc_pkg::COORD_BITS-1:0] off_x_nxt;
   logic [mpc_pkg::SX_BITS-1:0]    step_x_nxt;
   logic [mpc_pkg::PIX_BITS-1:0]   err_nxt;
   logic                           fin_step;
   logic                           fin_start;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign is_start  = (req.op == mpc_pkg::OP_START);

   // one octant step
   always_comb begin
      err_nonneg = !err_ff[mpc_pkg::PIX_BITS-1];
      off_y_mid  = err_nonneg ? off_y_ff - mpc_pkg::COORD_BITS'(1) : off_y_ff;
      step_y_mid = err_nonneg ? step_y_ff + mpc_pkg::PIX_BITS'(2) : step_y_ff;
      err_mid    = err_nonneg ? err_ff + step_y_mid : err_ff;
      off_x_nxt  = off_x_ff + mpc_pkg::COORD_BITS'(1);
      step_x_nxt = step_x_ff + mpc_pkg::SX_BITS'(2);
      err_nxt    = err_mid + mpc_pkg::PIX_BITS'(step_x_nxt);
      fin_step   = (off_x_nxt >= off_y_mid);
      fin_start  = (req.radius_in == '0);
   end

   assign push = accept && (is_start || active_ff);

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      mode_in   = mode_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      err_in    = err_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      active_in = active_ff;
      if (accept && is_start) begin
         cx_in     = req.center_x;
         cy_in     = req.center_y;
         mode_in   = req.draw_mode;
         off_x_in  = '0;
         off_y_in  = req.radius_in;
         err_in    = mpc_pkg::PIX_BITS'(1) - mpc_pkg::PIX_BITS'(req.radius_in);
         step_x_in = mpc_pkg::SX_BITS'(1);
         step_y_in = '0 - {1'b0, req.radius_in, 1'b0};
         active_in = !fin_start;
      end else if (accept && active_ff) begin
         off_x_in  = off_x_nxt;
         off_y_in  = off_y_mid;
         err_in    = err_nxt;
         step_x_in = step_x_nxt;
         step_y_in = step_y_mid;
         active_in = !fin_step;
      end
   end

   always_comb begin
      push_job.is_step = !is_start;
      push_job.cx      = is_start ? req.center_x  : cx_ff;
      push_job.cy      = is_start ? req.center_y  : cy_ff;
      push_job.mode    = is_start ? req.draw_mode : mode_ff;
      push_job.x       = is_start ? '0            : off_x_nxt;
      push_job.y       = is_start ? req.radius_in : off_y_mid;
      push_job.fin     = is_start ? fin_start     : fin_step;
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      mode_ff   <= mode_in;
      off_x_ff  <= off_x_in;
      off_y_ff  <= off_y_in;
      err_ff    <= err_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

FILE: rtl/core/mpc_queue.sv
// Small job queue between front end and pixel back end.
// Depends on mpc_pkg.
module mpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mpc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output mpc_pkg::job_type head_job
);

   mpc_pkg::job_type mem_ff [mpc_pkg::QUEUE_DEPTH];

   logic [mpc_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mpc_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mpc_pkg::QCNT_BITS-1:0] count_ff, count_in;

   assign full       = (count_ff == mpc_pkg::QCNT_BITS'(mpc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + mpc_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + mpc_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + mpc_pkg::QCNT_BITS'(1);
      end else if (!push && pop) begin
         count_in = count_ff - mpc_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/mpc_back.sv
// Back end: walks the symmetric pixels of the head job into the output
// register, one beat per cycle unless stalled. Depends on mpc_pkg, mpc_if.
module mpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  mpc_pkg::job_type job,
   output logic             pop,
   mpc_rsp_if.source        rsp
);

   logic [mpc_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mpc_pkg::PIX_BITS-1:0]   px_ff, px_in;
   logic [mpc_pkg::PIX_BITS-1:0]   py_ff, py_in;
   logic [mpc_pkg::MODE_BITS-1:0]  mode_ff;
   logic                           last_ff;
   logic                           done_ff;

   logic                           load;
   logic                           last_pix;
   logic [mpc_pkg::CNT_BITS-1:0]   sel;
   logic [mpc_pkg::COORD_BITS-1:0] mag_x;
   logic [mpc_pkg::COORD_BITS-1:0] mag_y;
   logic [mpc_pkg::PIX_BITS-1:0]   dx;
   logic [mpc_pkg::PIX_BITS-1:0]   dy;

   assign load     = job_valid && (!rsp_valid_ff || rsp.ready);
   assign last_pix = (cnt_ff == (job.is_step ? mpc_pkg::LAST_STEP_PIX
                                             : mpc_pkg::LAST_START_PIX));
   assign pop      = load && last_pix;

   // start beats map onto step slots 0, 2, 4, 5 with x = 0, y = r
   always_comb begin
      if (job.is_step) begin
         sel = cnt_ff;
      end else begin
         sel = {cnt_ff[1], cnt_ff[0] & !cnt_ff[1], cnt_ff[0] & cnt_ff[1]};
      end
      mag_x = sel[2] ? job.y : job.x;
      mag_y = sel[2] ? job.x : job.y;
      dx    = sel[0] ? '0 - mpc_pkg::PIX_BITS'(mag_x) : mpc_pkg::PIX_BITS'(mag_x);
      dy    = sel[1] ? '0 - mpc_pkg::PIX_BITS'(mag_y) : mpc_pkg::PIX_BITS'(mag_y);
      px_in = mpc_pkg::PIX_BITS'(job.cx) + dx;
      py_in = mpc_pkg::PIX_BITS'(job.cy) + dy;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (pop) begin
         cnt_in = '0;
      end else if (load) begin
         cnt_in = cnt_ff + mpc_pkg::CNT_BITS'(1);
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         mode_ff <= job.mode;
         last_ff <= last_pix;
         done_ff <= last_pix && job.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_x    = px_ff;
   assign rsp.pixel_y    = py_ff;
   assign rsp.pixel_mode = mode_ff;
   assign rsp.last       = last_ff;
   assign rsp.done_res   = done_ff;

   a_start_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job.is_step) |-> (cnt_ff <= mpc_pkg::LAST_START_PIX))
      else $error("start job beat index out of range");

   a_pop_clears_cnt: assert property (@(posedge clock) disable iff (reset)
      pop |=> (cnt_ff == '0))
      else $error("beat index not cleared after job completes");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> last_ff)
      else $error("done flagged on a beat that is not last");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded beat not presented");

endmodule

FILE: rtl/core/midpoint_circle_generator.sv
// Midpoint circle generator, top level: front end, job queue, pixel back end.
// Depends on mpc_pkg, mpc_if, mpc_front, mpc_queue, mpc_back.
//
// A start beat (op 0) latches center, radius and draw mode and yields four
// axis pixels; each step beat (op 1) advances the octant by one and yields
// eight symmetric pixels, the last flagged with last, and done_res set once
// the octant closes. A step while idle yields nothing. Pixels leave one per
// cycle while the pixel consumer is ready, from a registered output stage; that
// single pixel port sets the sustained rate. The front end updates the error
// term in the cycle it takes a beat and hands a job to a four-entry queue, so
// requests are taken back to back until the queue fills. A request's first pixel,
// with the queue empty, goes through the queue and then the output register.
module midpoint_circle_generator (
   input  logic       clock,
   input  logic       reset,
   mpc_req_if.sink    req_bus,
   mpc_rsp_if.source  rsp_bus
);

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             head_valid;
   mpc_pkg::job_type push_job;
   mpc_pkg::job_type head_job;

   mpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   mpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

FILE: tb/sv/midpoint_circle_generator_tb.sv
// Self-checking testbench for midpoint_circle_generator: directed table, then random
// start/step sequences under bursty request traffic and patterned pixel back-pressure.
// Depends on mpc_pkg, mpc_if and the RTL of the block.
`timescale 1ns / 1ps

module midpoint_circle_generator_tb;

   localparam int RANDOM_ITEMS = 430;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 24;

   typedef enum {CHK_PREDICT, CHK_NONE, CHK_AXIS, CHK_CENTER} check_kind_type;
   typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} stall_kind_type;

   typedef struct {
      logic                           op;
      logic [mpc_pkg::COORD_BITS-1:0] cx;
      logic [mpc_pkg::COORD_BITS-1:0] cy;
      logic [mpc_pkg::COORD_BITS-1:0] radius;
      logic [mpc_pkg::MODE_BITS-1:0]  mode;
   } circle_req_type;

   typedef struct {
      circle_req_type req;
      check_kind_type chk;
   } directed_row_type;

   typedef struct {
      logic signed [mpc_pkg::PIX_BITS-1:0] x;
      logic signed [mpc_pkg::PIX_BITS-1:0] y;
      logic [mpc_pkg::MODE_BITS-1:0]       mode;
      logic                                last;
      logic                                done;
   } pixel_type;

   logic clock;
   logic reset;

   mpc_req_if req_if();
   mpc_rsp_if rsp_if();

   midpoint_circle_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   pixel_type        pixels_due[$];
   directed_row_type directed[$];
   int               errors;
   int               burst_left;

   // circle state mirrored from the block
   logic [mpc_pkg::COORD_BITS-1:0] ctr_x;
   logic [mpc_pkg::COORD_BITS-1:0] ctr_y;
   logic [mpc_pkg::MODE_BITS-1:0]  ctr_mode;
   int                             off_x;
   int                             off_y;
   int                             err_term;
   int                             inc_x;
   int                             inc_y;
   bit                             armed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_pixel(ref pixel_type px[$], input int dx, input int dy,
                                      input bit is_last, input bit fin);
      pixel_type p;
      p.x    = mpc_pkg::PIX_BITS'(int'(ctr_x) + dx);
      p.y    = mpc_pkg::PIX_BITS'(int'(ctr_y) + dy);
      p.mode = ctr_mode;
      p.last = is_last;
      p.done = is_last && fin;
      px.push_back(p);
   endfunction

   function automatic void plot_request(input circle_req_type it, ref pixel_type px[$]);
      int r;
      bit fin;
      if (it.op == mpc_pkg::OP_START) begin
         r        = int'(it.radius);
         ctr_x    = it.cx;
         ctr_y    = it.cy;
         ctr_mode = it.mode;
         off_x    = 0;
         off_y    = r;
         err_term = 1 - r;
         inc_x    = 1;
         inc_y    = -2 * r;
         fin      = (r == 0);
         armed    = !fin;
         push_pixel(px, 0, r, 1'b0, fin);
         push_pixel(px, 0, -r, 1'b0, fin);
         push_pixel(px, r, 0, 1'b0, fin);
         push_pixel(px, -r, 0, 1'b1, fin);
      end else if (armed) begin
         if (err_term >= 0) begin
            off_y    = off_y - 1;
            inc_y    = inc_y + 2;
            err_term = err_term + inc_y;
         end
         off_x    = off_x + 1;
         inc_x    = inc_x + 2;
         err_term = err_term + inc_x;
         fin      = (off_x >= off_y);
         if (fin) armed = 1'b0;
         push_pixel(px, off_x, off_y, 1'b0, fin);
         push_pixel(px, -off_x, off_y, 1'b0, fin);
         push_pixel(px, off_x, -off_y, 1'b0, fin);
         push_pixel(px, -off_x, -off_y, 1'b0, fin);
         push_pixel(px, off_y, off_x, 1'b0, fin);
         push_pixel(px, -off_y, off_x, 1'b0, fin);
         push_pixel(px, off_y, -off_x, 1'b0, fin);
         push_pixel(px, -off_y, -off_x, 1'b1, fin);
      end
   endfunction

   function automatic void add_row(input logic op,
                                   input logic [mpc_pkg::COORD_BITS-1:0] cx,
                                   input logic [mpc_pkg::COORD_BITS-1:0] cy,
                                   input logic [mpc_pkg::COORD_BITS-1:0] r,
                                   input logic [mpc_pkg::MODE_BITS-1:0] mode,
                                   input check_kind_type chk);
      directed_row_type row;
      row.req.op     = op;
      row.req.cx     = cx;
      row.req.cy     = cy;
      row.req.radius = r;
      row.req.mode   = mode;
      row.chk        = chk;
      directed.push_back(row);
   endfunction

   // One request beat: pacing gap when a burst ends, handshake, then expected pixels.
   task automatic send_request(input circle_req_type it, input check_kind_type chk);
      pixel_type px[$];
      pixel_type p;
      int        sx[4] = '{0, 0, 1, -1};
      int        sy[4] = '{1, -1, 0, 0};
      int        d;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_if.valid     <= 1'b1;
      req_if.op        <= it.op;
      req_if.center_x  <= it.cx;
      req_if.center_y  <= it.cy;
      req_if.radius_in <= it.radius;
      req_if.draw_mode <= it.mode;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      plot_request(it, px);
      case (chk)
         CHK_PREDICT: begin
            foreach (px[k]) pixels_due.push_back(px[k]);
         end
         CHK_AXIS, CHK_CENTER: begin
            d = (chk == CHK_CENTER) ? 0 : int'(it.radius);
            for (int k = 0; k < 4; k++) begin
               p.x    = mpc_pkg::PIX_BITS'(int'(it.cx) + sx[k] * d);
               p.y    = mpc_pkg::PIX_BITS'(int'(it.cy) + sy[k] * d);
               p.mode = it.mode;
               p.last = (k == 3);
               p.done = (k == 3) && (chk == CHK_CENTER);
               pixels_due.push_back(p);
            end
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      circle_req_type it;
      int             counted;
      int             roll;
      errors     = 0;
      burst_left = 0;
      counted    = 0;
      ctr_x      = '0;
      ctr_y      = '0;
      ctr_mode   = '0;
      off_x      = 0;
      off_y      = 0;
      err_term   = 0;
      inc_x      = 1;
      inc_y      = 0;
      armed      = 1'b0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.op         <= mpc_pkg::OP_START;
      req_if.center_x   <= '0;
      req_if.center_y   <= '0;
      req_if.radius_in  <= '0;
      req_if.draw_mode  <= '0;

      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_NONE);
      add_row(mpc_pkg::OP_START, 10'd512,  10'd300,  10'd0,    8'hA5, CHK_CENTER);
      add_row(mpc_pkg::OP_STEP,  10'd1023, 10'd1023, 10'd1023, 8'hFF, CHK_NONE);
      add_row(mpc_pkg::OP_START, 10'd0,    10'd0,    10'd1023, 8'hFF, CHK_AXIS);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd1023, 10'd1023, 10'd1023, 8'hFF, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_START, 10'd1023, 10'd1023, 10'd1023, 8'h00, CHK_AXIS);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_START, 10'd100,  10'd200,  10'd1,    8'h3C, CHK_AXIS);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_NONE);
      add_row(mpc_pkg::OP_START, 10'd500,  10'd500,  10'd5,    8'h5A, CHK_PREDICT);
      repeat (4) add_row(mpc_pkg::OP_STEP, 10'd0, 10'd0, 10'd0, 8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_NONE);
      add_row(mpc_pkg::OP_START, 10'd10,   10'd20,   10'd8,    8'h01, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      // restart in the middle of a circle
      add_row(mpc_pkg::OP_START, 10'd1023, 10'd0,    10'd2,    8'hFF, CHK_AXIS);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);
      add_row(mpc_pkg::OP_STEP,  10'd0,    10'd0,    10'd0,    8'h00, CHK_PREDICT);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i].req, directed[i].chk);

      while (counted < RANDOM_ITEMS) begin
         it.cx   = mpc_pkg::COORD_BITS'($urandom_range(0, 1023));
         it.cy   = mpc_pkg::COORD_BITS'($urandom_range(0, 1023));
         it.mode = mpc_pkg::MODE_BITS'($urandom_range(0, 255));
         roll    = $urandom_range(0, 99);
         if (roll < 70)      it.radius = mpc_pkg::COORD_BITS'($urandom_range(0, 24));
         else if (roll < 90) it.radius = mpc_pkg::COORD_BITS'($urandom_range(25, 120));
         else                it.radius = mpc_pkg::COORD_BITS'($urandom_range(0, 1023));
         roll = $urandom_range(0, 99);
         if (armed)
            it.op = (roll < 2) ? mpc_pkg::OP_START
                  : (roll < 9) ? 1'($urandom_range(0, 1)) : mpc_pkg::OP_STEP;
         else
            it.op = (roll < 80) ? mpc_pkg::OP_START : mpc_pkg::OP_STEP;
         if (it.op == mpc_pkg::OP_START || armed) counted++;
         send_request(it, CHK_PREDICT);
      end
      req_if.valid <= 1'b0;

      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("midpoint_circle_generator_tb OK");
      end else begin
         $display("midpoint_circle_generator_tb NOT OK");
      end
      $finish;
   end

   // pixel sink: patterned back-pressure and in-order checking
   initial begin
      pixel_type      want;
      stall_kind_type kind;
      int             kind_left;
      int             phase;
      int             period;
      int             hold;
      bit             hold_level;
      bit             rdy;
      kind_left  = 0;
      kind       = RX_OPEN;
      phase      = 0;
      period     = 2;
      hold       = 0;
      hold_level = 1'b1;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pixels_due.size() == 0) begin
               $display("%0t: unexpected pixel beat x=%0d y=%0d", $time,
                        rsp_if.pixel_x, rsp_if.pixel_y);
               errors++;
            end else begin
               want = pixels_due.pop_front();
               if (rsp_if.pixel_x !== want.x) begin
                  $display("%0t: pixel_x expected %0d, got %0d", $time, want.x,
                           rsp_if.pixel_x);
                  errors++;
               end
               if (rsp_if.pixel_y !== want.y) begin
                  $display("%0t: pixel_y expected %0d, got %0d", $time, want.y,
                           rsp_if.pixel_y);
                  errors++;
               end
               if (rsp_if.pixel_mode !== want.mode) begin
                  $display("%0t: pixel_mode expected %0h, got %0h", $time, want.mode,
                           rsp_if.pixel_mode);
                  errors++;
               end
               if (rsp_if.last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last,
                           rsp_if.last);
                  errors++;
               end
               if (rsp_if.done_res !== want.done) begin
                  $display("%0t: done_res expected %0b, got %0b", $time, want.done,
                           rsp_if.done_res);
                  errors++;
               end
            end
         end
         if (kind_left == 0) begin
            kind      = stall_kind_type'($urandom_range(0, 3));
            kind_left = $urandom_range(40, 200);
            period    = $urandom_range(2, 5);
            hold      = 0;
         end
         kind_left--;
         phase++;
         case (kind)
            RX_OPEN:     rdy = 1'b1;
            RX_RANDOM:   rdy = ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rdy = ((phase % period) != 0);
            default: begin
               if (hold == 0) begin
                  hold_level = !hold_level;
                  hold       = $urandom_range(1, 8);
               end
               hold--;
               rdy = hold_level;
            end
         endcase
         rsp_if.ready <= rdy;
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("midpoint_circle_generator_tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/mpc_pkg.sv
rtl/core/mpc_if.sv
rtl/core/mpc_front.sv
rtl/core/mpc_queue.sv
rtl/core/mpc_back.sv
rtl/core/midpoint_circle_generator.sv
tb/sv/midpoint_circle_generator_tb.sv
